[rtl/ordered_list_insert_delete_search_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list unit
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge.
`define OLIDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define OLIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OLIDS_ASSERT(lbl, prop, msg)
`define OLIDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/olids_pkg.sv]
// ----------------------------------------------------------------------------
// olids_pkg
// Shared types and constants of the ordered list unit.
// ----------------------------------------------------------------------------
package olids_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int POS_W         = 6;
  localparam int IDX_OUT_W     = 5;
  localparam int CNT_OUT_W     = 6;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 112;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_REMOVE_AT  = 3'd2,
    CMD_REMOVE_VAL = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_READ_AT    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // per-cell control for one cycle
  typedef struct packed {
    logic                     load;       // take the command value
    logic                     shift_up;   // take the left neighbor
    logic                     shift_down; // take the right neighbor
    logic                     compare;    // register the match flag
    logic                     valid;      // cell lies below the count
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

[rtl/ordered_list_insert_delete_search_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search_unit
// Ordered list of signed 32-bit entries in a row of shifting cells.
// ----------------------------------------------------------------------------
// The list lives in a chain of DEPTH cells, one entry per cell, with a count
// of valid entries. Commands arrive one transaction at a time and each gives
// exactly one result transaction. Append, insert at, remove at and read at
// pass through an execute state (every cell loads, shifts from a neighbor or
// holds), then a gather state in which the result is gathered; remove value
// and search first pass through a state in which every cell compares its
// entry and a state in which the lowest match is isolated. A new command can
// be accepted in the gather state of the previous one, without a return to
// idle, as long as the output is free. The result sits in an output
// register, and the unit takes the next command while it waits; a stall on
// the result side holds the unit only once the next result is ready.
// Entries are not cleared at reset; only slots below the count are ever read.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_search_unit_macros.svh"

module ordered_list_insert_delete_search_unit #(
  parameter int DEPTH = olids_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command[2:0], position[8:3], value[40:9], zero fill
  input  logic [olids_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status[1:0], found_index[6:2], read_value[38:7], entry_count[44:39],
  // first_value[76:45], last_value[108:77], zero fill
  output logic [olids_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > olids_pkg::POS_W) ? CW : olids_pkg::POS_W;
  localparam int DW = olids_pkg::DATA_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam logic [XW-1:0] ONE_X   = XW'(1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FIND = 5'b00100,
    S_EXEC = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // incoming transaction fields
  logic [olids_pkg::CMD_W-1:0] in_cmd;
  logic [olids_pkg::POS_W-1:0] in_pos;
  logic signed [DW-1:0]        in_val;
  logic                        s_accept;
  logic                        out_free;
  logic                        in_value_cmd;

  // latched command
  logic [olids_pkg::CMD_W-1:0] cmd_q;
  logic [olids_pkg::POS_W-1:0] pos_q;
  logic signed [DW-1:0]        val_q;

  logic [CW-1:0]               count;
  logic [XW-1:0]               count_x;
  logic [XW-1:0]               pos_x;
  logic                        full;

  olids_pkg::status_t          exec_status;
  olids_pkg::status_t          status_q;
  logic [XW-1:0]               exec_idx;
  logic [XW-1:0]               idx_q;
  logic                        exec_ok;

  // cell row
  olids_pkg::cell_ctrl_t       cell_ctrl [DEPTH];
  logic signed [DW-1:0]        entry     [DEPTH];
  logic [DEPTH-1:0]            match_vec;
  logic [DEPTH-1:0]            ge_hit;
  logic [XW-1:0]               hit_index;
  logic                        hit_found;

  // gather buses
  logic signed [DW-1:0]        rd_bus;
  logic signed [DW-1:0]        last_bus;

  // output register
  olids_pkg::status_t          o_status;
  logic [olids_pkg::IDX_OUT_W-1:0] o_index;
  logic signed [DW-1:0]        o_read;
  logic [olids_pkg::CNT_OUT_W-1:0] o_count;
  logic signed [DW-1:0]        o_first;
  logic signed [DW-1:0]        o_last;

  assign in_cmd = s_axis_tdata[2:0];
  assign in_pos = s_axis_tdata[8:3];
  assign in_val = s_axis_tdata[40:9];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_value_cmd  = (in_cmd == olids_pkg::CMD_REMOVE_VAL) ||
                         (in_cmd == olids_pkg::CMD_SEARCH);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          state_next = in_value_cmd ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: state_next = S_FIND;
      S_FIND: state_next = S_EXEC;
      S_EXEC: state_next = S_DONE;
      S_DONE: begin
        if (s_accept) begin
          state_next = in_value_cmd ? S_SCAN : S_EXEC;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      cmd_q <= in_cmd;
      pos_q <= in_pos;
      val_q <= in_val;
    end
  end

  // --------------------------------------------------------------------------
  // status and count decision, used in the execute cycle
  // --------------------------------------------------------------------------
  assign count_x = XW'(count);
  assign pos_x   = XW'(pos_q);
  assign full    = (count_x >= DEPTH_X);

  always_comb begin
    exec_status = olids_pkg::ST_OK;
    exec_idx    = '0;
    case (cmd_q)
      olids_pkg::CMD_APPEND: begin
        if (full) exec_status = olids_pkg::ST_FULL;
      end
      olids_pkg::CMD_INSERT: begin
        if (full) begin
          exec_status = olids_pkg::ST_FULL;
        end else if (pos_x > count_x) begin
          exec_status = olids_pkg::ST_BAD_POS;
        end
      end
      olids_pkg::CMD_REMOVE_AT: begin
        if (pos_x >= count_x) exec_status = olids_pkg::ST_BAD_POS;
      end
      olids_pkg::CMD_READ_AT: begin
        if (pos_x >= count_x) begin
          exec_status = olids_pkg::ST_BAD_POS;
        end else begin
          exec_idx = pos_x;
        end
      end
      olids_pkg::CMD_REMOVE_VAL, olids_pkg::CMD_SEARCH: begin
        if (hit_found) begin
          exec_idx = hit_index;
        end else begin
          exec_status = olids_pkg::ST_NOT_FOUND;
        end
      end
      default: exec_status = olids_pkg::ST_BAD_POS;
    endcase
  end

  assign exec_ok = (state == S_EXEC) && (exec_status == olids_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      status_q <= exec_status;
      idx_q    <= exec_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_ok) begin
      if ((cmd_q == olids_pkg::CMD_APPEND) || (cmd_q == olids_pkg::CMD_INSERT)) begin
        count <= count + CW'(1);
      end else if ((cmd_q == olids_pkg::CMD_REMOVE_AT) ||
                   (cmd_q == olids_pkg::CMD_REMOVE_VAL)) begin
        count <= count - CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // cell row: each slot decodes its own move from the broadcast command
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [XW-1:0] IX = XW'(i);
    logic signed [DW-1:0] left_in;
    logic signed [DW-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = entry[i];
    end else begin : g_body_l
      assign left_in = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in = entry[i];
    end else begin : g_body_r
      assign right_in = entry[i+1];
    end

    assign cell_ctrl[i].load = exec_ok &&
      (((cmd_q == olids_pkg::CMD_APPEND) && (IX == count_x)) ||
       ((cmd_q == olids_pkg::CMD_INSERT) && (IX == pos_x)));
    assign cell_ctrl[i].shift_up = exec_ok &&
      (cmd_q == olids_pkg::CMD_INSERT) && (IX > pos_x);
    assign cell_ctrl[i].shift_down = exec_ok &&
      (((cmd_q == olids_pkg::CMD_REMOVE_AT) && (IX >= pos_x)) ||
       ((cmd_q == olids_pkg::CMD_REMOVE_VAL) && ge_hit[i]));
    assign cell_ctrl[i].compare = (state == S_SCAN);
    assign cell_ctrl[i].valid   = (IX < count_x);
    assign cell_ctrl[i].value   = val_q;

    olids_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (cell_ctrl[i]),
      .left  (left_in),
      .right (right_in),
      .entry (entry[i]),
      .match (match_vec[i])
    );
  end

  olids_first #(
    .DEPTH (DEPTH),
    .XW    (XW)
  ) u_first (
    .clk   (clk),
    .rst   (rst),
    .load  (state == S_FIND),
    .match (match_vec),
    .ge    (ge_hit),
    .index (hit_index),
    .found (hit_found)
  );

  // --------------------------------------------------------------------------
  // gather: read position and last slot, after the row has settled
  // --------------------------------------------------------------------------
  always_comb begin
    rd_bus   = '0;
    last_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (XW'(i) == pos_x) rd_bus = rd_bus | entry[i];
      if (XW'(i) == (count_x - ONE_X)) last_bus = last_bus | entry[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      o_status <= status_q;
      o_index  <= idx_q[olids_pkg::IDX_OUT_W-1:0];
      o_read   <= ((cmd_q == olids_pkg::CMD_READ_AT) && (status_q == olids_pkg::ST_OK))
                  ? rd_bus : '0;
      o_count  <= count_x[olids_pkg::CNT_OUT_W-1:0];
      o_first  <= (count != '0) ? entry[0] : '0;
      o_last   <= (count != '0) ? last_bus : '0;
    end
  end

  assign m_axis_tdata = {3'b000, o_last, o_first, o_count, o_read, o_index, o_status};

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `OLIDS_ASSERT(a_count_range, count_x <= DEPTH_X, "count exceeds depth")
  `OLIDS_ASSERT(a_count_in_exec, !$stable(count) |-> $past(state == S_EXEC), "stray count change")
  `OLIDS_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(state == S_DONE), "stray result")
  `OLIDS_ASSERT_NEXT(a_exec_to_done, state == S_EXEC, state == S_DONE, "no gather after execute")

endmodule

[rtl/olids_cell.sv]
// ----------------------------------------------------------------------------
// olids_cell
// One list slot: holds an entry, shifts with its neighbors, compares.
// ----------------------------------------------------------------------------
module olids_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  olids_pkg::cell_ctrl_t             ctrl,
  input  logic signed [olids_pkg::DATA_W-1:0] left,
  input  logic signed [olids_pkg::DATA_W-1:0] right,
  output logic signed [olids_pkg::DATA_W-1:0] entry,
  output logic                              match
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= ctrl.value;
    end else if (ctrl.shift_up) begin
      entry <= left;
    end else if (ctrl.shift_down) begin
      entry <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.compare) begin
      match <= ctrl.valid && (entry == ctrl.value);
    end
  end

endmodule

[rtl/olids_first.sv]
// ----------------------------------------------------------------------------
// olids_first
// Isolates the lowest match, gives its index and an at-or-above mask.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_search_unit_macros.svh"

module olids_first #(
  parameter int DEPTH = olids_pkg::DEPTH_DEFAULT,
  parameter int XW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [DEPTH-1:0] match,
  output logic [DEPTH-1:0] ge,
  output logic [XW-1:0]    index,
  output logic             found
);

  localparam logic [DEPTH-1:0] ONE = DEPTH'(1);

  logic [DEPTH-1:0] hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= '0;
    end else if (load) begin
      hit <= match & (~match + ONE);
    end
  end

  // all ones from the hit upward; zero when nothing hit
  assign ge    = ~(hit - ONE);
  assign found = |hit;

  always_comb begin
    index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        index = index | XW'(i);
      end
    end
  end

  `OLIDS_ASSERT(a_hit_onehot, $onehot0(hit), "more than one hit bit set")

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list unit testbench
// Streams list commands into the unit, keeps its own image of the list to
// work out each result, and checks every result transaction field by field
// while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIST_DEPTH   = olids_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 880;
  localparam int HOLD_CYCLES  = 160;

  // command codes the unit does not implement
  localparam logic [olids_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [olids_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [5:0]                  count;
    logic [LIST_DEPTH-1:0][31:0] slots;
  } list_t;

  typedef struct packed {
    olids_pkg::status_t status;
    logic [4:0]         index;
    logic [31:0]        rd_value;
    logic [5:0]         count;
    logic [31:0]        first;
    logic [31:0]        last;
  } list_reply_t;

  typedef struct packed {
    logic [olids_pkg::CMD_W-1:0] cmd;
    logic [5:0]                  pos;
    logic [31:0]                 val;
    logic                        drain;  // hold off until every result is back
  } list_cmd_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [olids_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [olids_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  list_cmd_t   cmd_queue[$];
  list_reply_t pending_replies[$];
  list_t       list_image;
  list_t       plan_list;
  list_reply_t want;
  list_reply_t got;
  list_cmd_t   nxt;
  bit          cmd_taken;
  int          cmds_taken;
  int          total_cmds;
  int          replies_seen;
  int          mismatches;
  int          send_gap;
  int          stall_left;
  int          hold_left;
  int          holds_done;

  ordered_list_insert_delete_search_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one command against a list image; returns the result it gives
  function automatic void apply_list_command(inout list_t lst, input logic [2:0] cmd,
                                             input logic [5:0] pos, input logic [31:0] val,
                                             output list_reply_t r);
    int n;
    int k;
    int i;
    n = int'(lst.count);
    r = '0;
    r.status = olids_pkg::ST_OK;
    case (cmd)
      olids_pkg::CMD_APPEND: begin
        if (n >= LIST_DEPTH) begin
          r.status = olids_pkg::ST_FULL;
        end else begin
          lst.slots[n] = val;
          n++;
        end
      end
      olids_pkg::CMD_INSERT: begin
        // fullness wins over a bad position
        if (n >= LIST_DEPTH) begin
          r.status = olids_pkg::ST_FULL;
        end else if (pos > n) begin
          r.status = olids_pkg::ST_BAD_POS;
        end else begin
          for (i = n; i > pos; i--) lst.slots[i] = lst.slots[i-1];
          lst.slots[pos] = val;
          n++;
        end
      end
      olids_pkg::CMD_REMOVE_AT: begin
        if (pos >= n) begin
          r.status = olids_pkg::ST_BAD_POS;
        end else begin
          for (i = pos; i + 1 < n; i++) lst.slots[i] = lst.slots[i+1];
          n--;
        end
      end
      olids_pkg::CMD_REMOVE_VAL, olids_pkg::CMD_SEARCH: begin
        k = n;
        for (i = n - 1; i >= 0; i--) if (lst.slots[i] == val) k = i;
        if (k == n) begin
          r.status = olids_pkg::ST_NOT_FOUND;
        end else begin
          r.index = k[4:0];
          if (cmd == olids_pkg::CMD_REMOVE_VAL) begin
            for (i = k; i + 1 < n; i++) lst.slots[i] = lst.slots[i+1];
            n--;
          end
        end
      end
      olids_pkg::CMD_READ_AT: begin
        if (pos >= n) begin
          r.status = olids_pkg::ST_BAD_POS;
        end else begin
          r.index    = pos[4:0];
          r.rd_value = lst.slots[pos];
        end
      end
      default: r.status = olids_pkg::ST_BAD_POS;
    endcase
    lst.count = n[5:0];
    r.count   = n[5:0];
    r.first   = (n > 0) ? lst.slots[0] : '0;
    r.last    = (n > 0) ? lst.slots[n-1] : '0;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] seen,
                               input logic [31:0] exp_val);
    mismatches++;
    $display("MISMATCH result %0d %s: got %h, want %h", replies_seen, field, seen, exp_val);
  endtask

  // queue a command and track the list it leaves behind
  task automatic add_cmd(input logic [2:0] cmd, input logic [5:0] pos,
                         input logic [31:0] val, input logic drain);
    list_reply_t unused;
    list_cmd_t   c;
    c.cmd   = cmd;
    c.pos   = pos;
    c.val   = val;
    c.drain = drain;
    cmd_queue.push_back(c);
    apply_list_command(plan_list, cmd, pos, val, unused);
  endtask

  // Monitor: results are checked before the command accepted at the same
  // edge is predicted; that result always belongs to an older command.
  always @(posedge clk) begin
    cmd_taken = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        replies_seen++;
        got.status   = olids_pkg::status_t'(m_axis_tdata[1:0]);
        got.index    = m_axis_tdata[6:2];
        got.rd_value = m_axis_tdata[38:7];
        got.count    = m_axis_tdata[44:39];
        got.first    = m_axis_tdata[76:45];
        got.last     = m_axis_tdata[108:77];
        if (pending_replies.size() == 0) begin
          note_mismatch("unexpected transaction", got.status, '0);
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status)
            note_mismatch("status", got.status, want.status);
          if (got.index !== want.index)
            note_mismatch("found_index", got.index, want.index);
          if (got.rd_value !== want.rd_value)
            note_mismatch("read_value", got.rd_value, want.rd_value);
          if (got.count !== want.count)
            note_mismatch("entry_count", got.count, want.count);
          if (got.first !== want.first)
            note_mismatch("first_value", got.first, want.first);
          if (got.last !== want.last)
            note_mismatch("last_value", got.last, want.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_taken = 1'b1;
        cmds_taken++;
        apply_list_command(list_image, s_axis_tdata[2:0], s_axis_tdata[8:3],
                           s_axis_tdata[40:9], want);
        pending_replies.push_back(want);
      end
    end
  end

  // Command driver: no gaps near the end and in every fourth window of 60
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !cmd_taken) begin
      // transaction still offered
    end else if (send_gap > 0) begin
      send_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (cmd_queue.size() == 0 ||
                 (cmd_queue[0].drain && pending_replies.size() != 0)) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nxt = cmd_queue.pop_front();
      s_axis_tdata  <= {7'd0, nxt.val, nxt.pos, nxt.cmd};
      s_axis_tvalid <= 1'b1;
      if (cmds_taken < total_cmds - 80 && (cmds_taken / 60) % 4 != 3 &&
          $urandom_range(0, 3) == 0)
        send_gap = $urandom_range(1, 7);
    end
  end

  // Result receiver: random stalls plus two long hold-offs that back the
  // unit up into its command port
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holds_done < 2 && replies_seen >= 150 + 370 * holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (replies_seen < total_cmds - 80 && (replies_seen / 70) % 4 != 3 &&
          $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 7);
    end
  end

  // Stimulus and end of run
  initial begin
    logic [2:0]  cmd;
    logic [5:0]  pos;
    logic [31:0] val;
    int          n;
    int          roll;
    bit          grow;
    plan_list  = '0;
    list_image = '0;

    // directed: empty list, extremes, duplicates, bad positions, spare codes
    add_cmd(olids_pkg::CMD_SEARCH,     6'd0,  32'd5,         1'b0);
    add_cmd(olids_pkg::CMD_REMOVE_VAL, 6'd0,  32'd5,         1'b0);
    add_cmd(olids_pkg::CMD_READ_AT,    6'd0,  32'd0,         1'b0);
    add_cmd(olids_pkg::CMD_REMOVE_AT,  6'd0,  32'd0,         1'b0);
    add_cmd(olids_pkg::CMD_INSERT,     6'd1,  32'd9,         1'b0);
    add_cmd(olids_pkg::CMD_INSERT,     6'd0,  VAL_MIN,       1'b0);
    add_cmd(olids_pkg::CMD_APPEND,     6'd0,  VAL_MAX,       1'b0);
    add_cmd(olids_pkg::CMD_APPEND,     6'd63, 32'hFFFF_FFFF, 1'b0);
    add_cmd(olids_pkg::CMD_INSERT,     6'd3,  32'd0,         1'b0);
    add_cmd(olids_pkg::CMD_INSERT,     6'd1,  32'h5555_AAAA, 1'b0);
    add_cmd(olids_pkg::CMD_APPEND,     6'd0,  32'hFFFF_FFFF, 1'b0);
    add_cmd(olids_pkg::CMD_SEARCH,     6'd0,  32'hFFFF_FFFF, 1'b0);
    add_cmd(olids_pkg::CMD_READ_AT,    6'd5,  32'd0,         1'b0);
    add_cmd(olids_pkg::CMD_READ_AT,    6'd6,  32'd0,         1'b0);
    add_cmd(olids_pkg::CMD_READ_AT,    6'd63, 32'd0,         1'b0);
    add_cmd(olids_pkg::CMD_INSERT,     6'd7,  32'd1,         1'b0);
    add_cmd(olids_pkg::CMD_REMOVE_VAL, 6'd0,  32'hFFFF_FFFF, 1'b0);
    add_cmd(olids_pkg::CMD_REMOVE_AT,  6'd0,  32'd0,         1'b0);
    add_cmd(olids_pkg::CMD_REMOVE_AT,  6'd3,  32'd0,         1'b0);
    add_cmd(CMD_SPARE_6,               6'd0,  32'd0,         1'b0);
    add_cmd(CMD_SPARE_7,               6'd63, 32'hFFFF_FFFF, 1'b0);
    add_cmd(olids_pkg::CMD_INSERT,     6'd32, 32'hAAAA_5555, 1'b0);
    add_cmd(olids_pkg::CMD_SEARCH,     6'd0,  32'h5555_AAAA, 1'b0);

    // random: alternate growing to full and shrinking to empty
    grow = 1'b1;
    for (int j = 0; j < RANDOM_ITEMS; j++) begin
      n = int'(plan_list.count);
      if (n == 0)
        grow = 1'b1;
      else if (n == LIST_DEPTH && $urandom_range(0, 3) == 0)
        grow = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        cmd = 3'($urandom_range(6, 7));
      else if (roll < 45)
        cmd = grow ? ($urandom_range(0, 1) ? olids_pkg::CMD_APPEND : olids_pkg::CMD_INSERT)
                   : ($urandom_range(0, 1) ? olids_pkg::CMD_REMOVE_AT
                                           : olids_pkg::CMD_REMOVE_VAL);
      else
        cmd = 3'($urandom_range(0, 5));

      // small pool and present entries make searches hit, often duplicates
      case ($urandom_range(0, 3))
        0: val = $urandom_range(0, 7) - 4;
        1: val = (n > 0) ? plan_list.slots[$urandom_range(0, n - 1)] : $urandom;
        2: val = $urandom;
        default: val = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      endcase

      if ($urandom_range(0, 9) == 0)
        pos = 6'($urandom_range(0, 63));
      else if (cmd == olids_pkg::CMD_INSERT)
        pos = 6'($urandom_range(0, n));
      else
        pos = (n > 0) ? 6'($urandom_range(0, n - 1)) : 6'd0;

      add_cmd(cmd, pos, val, (j == 300 || j == 600));
    end
    total_cmds = cmd_queue.size();

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (cmds_taken < total_cmds || pending_replies.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("[ordered_list_insert_delete_search_unit] OK");
    else
      $display("[ordered_list_insert_delete_search_unit] ERROR");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("[ordered_list_insert_delete_search_unit] ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/olids_pkg.sv
rtl/olids_cell.sv
rtl/olids_first.sv
rtl/ordered_list_insert_delete_search_unit.sv
test/testbench.sv
